FILE: rtl/core/vdrs_pkg.sv
`timescale 1ns / 1ps

package vdrs_pkg;

    // Voice count limit and the widths that follow from it
    localparam int MAX_VOICES = 16;
    localparam int IDX_W      = $clog2(MAX_VOICES);
    localparam int VCNT_W     = $clog2(MAX_VOICES + 1);

    // Field widths
    localparam int AMT_W   = 16;
    localparam int VCIN_W  = 5;
    localparam int NOTE_W  = 7;
    localparam int VIDX_W  = 4;
    localparam int RATIO_W = 24;

    // Configuration port
    localparam int   PADDR_W      = 3;
    localparam int   PDATA_W      = 32;
    localparam logic REG_IDX_RANGE = 1'b0;
    localparam logic [AMT_W-1:0] RANGE_RESET = 16'd12800;

    // Note scaling: factor numerator is NOTE_BASE + (note-1)/7, over 127
    localparam int KF_W       = 7;
    localparam int NOTE_BASE  = 109;
    localparam int K_RECIP    = 147;   // floor(x/7) == (x*147) >> 10 for x < 127
    localparam int K_RECIP_SH = 10;

    // Arithmetic widths
    localparam int C_W      = 32;
    localparam int CF_W     = C_W + KF_W;
    localparam int NUM_W    = CF_W + IDX_W;
    localparam int unsigned DEN_UNIT = 39014400;   // 256 * 127 * 1200
    localparam int DEN_W    = $clog2(longint'(DEN_UNIT) * (MAX_VOICES - 1) + 1);
    localparam int DIV_W    = DEN_W;
    localparam int QINT_W   = 5;
    localparam int FRAC_W   = 32;
    localparam int QUOT_W   = QINT_W + FRAC_W;
    localparam int STEP_W   = $clog2(QUOT_W + 1);
    localparam int EXP_STEPS = 24;
    localparam int MANT_W   = 32;

    localparam logic [RATIO_W-1:0] ONE_Q22 = 24'h400000;
    localparam logic [RATIO_W-1:0] MAX_Q22 = 24'hFFFFFF;

    typedef struct packed {
        logic [AMT_W-1:0]  detune_cents;
        logic [VCIN_W-1:0] voice_count;
        logic [NOTE_W-1:0] note_number;
    } in_t;

    typedef struct packed {
        logic [VIDX_W-1:0]  voice_index;
        logic [RATIO_W-1:0] pitch_ratio;
        logic               last_voice;
    } out_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [QUOT_W-1:0] stream;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    // Entry j holds 2^(2^-(j+1)) in Q1.30
    typedef logic [EXP_STEPS-1:0][MANT_W-1:0] root_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] xv;
        r  = '0;
        b  = 64'h1 << 62;
        xv = x;
        for (int n = 0; n < 32; n++)
        begin
            if (xv >= r + b)
            begin
                xv = xv - (r + b);
                r  = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic root_tab_t build_root_tab();
        logic [63:0] prev;
        root_tab_t   t;
        prev = isqrt64(64'h1 << 61);
        t[0] = prev[MANT_W-1:0];
        for (int j = 1; j < EXP_STEPS; j++)
        begin
            prev = isqrt64(prev << 30);
            t[j] = prev[MANT_W-1:0];
        end
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

FILE: rtl/core/voice_detune_ratio_spread.sv
`timescale 1ns / 1ps

// Unison detune ratio generator. Each request transaction (detune amount,
// voice count, MIDI note) produces one result transaction per voice, in voice
// order, carrying the voice index, a Q2.22 frequency ratio and a last mark on
// the final voice. Voice 0 is always 1.0; other voices alternate below (odd)
// and above (even) with a spread that grows linearly with the voice index.
// The amount is taken against the full-scale range register (APB offset 0,
// Q8.8 cents), bent upward past half range. The block handles one request at
// a time and stalls its request side until the last result is taken. After
// acceptance it runs its setup steps and, when the amount is bent, the
// bent-amount division; then it handles each voice in turn. Voice 0 (likewise
// every voice of a single-voice request, or a voice saturated at 32 octaves or
// more) is presented directly; every other voice is issued to the shared
// bit-serial divider, run through the sequential exp2 multiplier and then
// presented. The block returns to idle before the next request is taken, and
// a stalled result is held until it is taken.
module voice_detune_ratio_spread (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            req_valid,
    output logic                            req_stall,
    input  vdrs_pkg::in_t                   req_data,
    // result channel
    output logic                            res_valid,
    input  logic                            res_stall,
    output vdrs_pkg::out_t                  res_data,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vdrs_pkg::PADDR_W-1:0]    paddr,
    input  logic [vdrs_pkg::PDATA_W-1:0]    pwdata,
    output logic [vdrs_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import vdrs_pkg::*;

    localparam int SH_W    = 6;
    localparam int SH_ZERO = 40;   // right shifts this large leave nothing

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CDIV,
        ST_SCALE,
        ST_VOICE,
        ST_VDIV,
        ST_EXP,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [AMT_W-1:0]   range_reg, range_next;
    logic [AMT_W-1:0]   d_reg, d_next;
    logic [VCNT_W-1:0]  vcnt_reg, vcnt_next;
    logic [KF_W-1:0]    kfac_reg, kfac_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [C_W-1:0]     c_reg, c_next;
    logic [CF_W-1:0]    cf_reg, cf_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [QINT_W-1:0]  q_reg, q_next;
    logic               fz_reg, fz_next;
    out_t               res_reg, res_next;

    div_req_t              div_req;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;
    logic                  exp_start;
    logic [EXP_STEPS-1:0]  exp_frac;
    logic                  exp_done;
    logic [MANT_W-1:0]     exp_mant;

    logic cfg_wr;
    logic req_acc;
    logic is_last;
    logic neg;

    // Final scaling of the Q1.30 mantissa to Q2.22 with rounding half up.
    // Odd voices use 2^-(q) when the fraction is zero, else 2^-(q+1) * 2^(1-f).
    function automatic logic [RATIO_W-1:0] ratio_q22(
        input logic [MANT_W-1:0] m,
        input logic [QINT_W-1:0] q,
        input logic              ng,
        input logic              fz
    );
        logic [MANT_W+1:0]  tp;
        logic [SH_W-1:0]    sh;
        logic [MANT_W+9:0]  tn;
        logic [MANT_W+9:0]  vv;
        logic [RATIO_W-1:0] r;
        tp = ({2'b00, m} << q[0]) + (MANT_W+2)'(128);
        sh = SH_W'(q) + (fz ? SH_W'(8) : SH_W'(9));
        tn = {10'b0, m} + ((MANT_W+10)'(1) << (sh - SH_W'(1)));
        vv = tn >> sh;
        if (!ng)
        begin
            if (q >= QINT_W'(2))
                r = MAX_Q22;
            else if ((tp >> 8) > (MANT_W+2)'(MAX_Q22))
                r = MAX_Q22;
            else
                r = tp[RATIO_W+7:8];
        end
        else
        begin
            if (sh >= SH_W'(SH_ZERO))
                r = '0;
            else if (vv > (MANT_W+10)'(MAX_Q22))
                r = MAX_Q22;
            else
                r = vv[RATIO_W-1:0];
        end
        return r;
    endfunction

    vdrs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    vdrs_exp2 u_exp2 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .frac  (exp_frac),
        .done  (exp_done),
        .mant  (exp_mant)
    );

    // APB: zero-wait writes; the range register sits at offset 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_RANGE);

    always_comb
    begin
        if (paddr[2] == REG_IDX_RANGE)
            prdata = {{(PDATA_W-AMT_W){1'b0}}, range_reg};
        else
            prdata = '0;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign res_valid = (state_reg == ST_OUT);
    assign res_data  = res_reg;

    assign is_last = (VCNT_W'(idx_reg) == vcnt_reg - VCNT_W'(1));
    assign neg     = idx_reg[0];

    always_comb
    begin
        logic [NOTE_W-1:0]    nidx;
        logic [NOTE_W+7:0]    kmul;
        logic [2*AMT_W-1:0]   rr;
        logic [2*AMT_W-1:0]   dd;
        logic [2*AMT_W:0]     nsum;
        logic [FRAC_W-1:0]    frac;
        logic [FRAC_W-1:0]    negf;

        state_next = state_reg;
        range_next = range_reg;
        d_next     = d_reg;
        vcnt_next  = vcnt_reg;
        kfac_next  = kfac_reg;
        den_next   = den_reg;
        c_next     = c_reg;
        cf_next    = cf_reg;
        num_next   = num_reg;
        idx_next   = idx_reg;
        q_next     = q_reg;
        fz_next    = fz_reg;
        res_next   = res_reg;
        div_req    = '0;
        exp_start  = 1'b0;
        exp_frac   = '0;

        nidx = (req_data.note_number == '0) ? '0 : req_data.note_number - NOTE_W'(1);
        kmul = (NOTE_W+8)'(nidx) * (NOTE_W+8)'(K_RECIP);
        rr   = range_reg * range_reg;
        dd   = d_reg * d_reg;
        nsum = {1'b0, rr} + {1'b0, dd};
        frac = div_quot[FRAC_W-1:0];
        negf = '0 - frac;

        if (cfg_wr)
        begin
            range_next = pwdata[AMT_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Capture the request; clamp the voice count, reduce the note
                if (req_acc)
                begin
                    d_next = req_data.detune_cents;
                    if (req_data.voice_count == '0)
                        vcnt_next = VCNT_W'(1);
                    else if (int'(req_data.voice_count) > MAX_VOICES)
                        vcnt_next = VCNT_W'(MAX_VOICES);
                    else
                        vcnt_next = VCNT_W'(req_data.voice_count);
                    kfac_next  = KF_W'(NOTE_BASE) + KF_W'(kmul >> K_RECIP_SH);
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                // Per-voice denominator, then the effective (bent) amount
                den_next = DEN_W'(DEN_UNIT) * DEN_W'(vcnt_reg - VCNT_W'(1));
                if (range_reg == '0)
                begin
                    c_next     = '0;
                    state_next = ST_SCALE;
                end
                else if ({d_reg, 1'b0} <= {1'b0, range_reg})
                begin
                    c_next     = C_W'(d_reg);
                    state_next = ST_SCALE;
                end
                else
                begin
                    // (R*R + D*D) / (2R): 32 quotient bits
                    div_req.start    = 1'b1;
                    div_req.rem_init = DIV_W'(nsum[2*AMT_W]);
                    div_req.stream   = {nsum[2*AMT_W-1:0], (QUOT_W-2*AMT_W)'(0)};
                    div_req.steps    = STEP_W'(C_W);
                    div_req.divisor  = DIV_W'({range_reg, 1'b0});
                    state_next       = ST_CDIV;
                end
            end
            ST_CDIV:
            begin
                if (div_done)
                begin
                    c_next     = div_quot[C_W-1:0];
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                // Per-voice step of the exponent numerator
                cf_next    = CF_W'(c_reg) * CF_W'(kfac_reg);
                num_next   = '0;
                idx_next   = '0;
                state_next = ST_VOICE;
            end
            ST_VOICE:
            begin
                res_next.voice_index = VIDX_W'(idx_reg);
                res_next.last_voice  = is_last;
                if ((idx_reg == '0) || (den_reg == '0))
                begin
                    res_next.pitch_ratio = ONE_Q22;
                    state_next           = ST_OUT;
                end
                else if ((num_reg >> QINT_W) >= NUM_W'(den_reg))
                begin
                    // 32 octaves or more: saturate
                    res_next.pitch_ratio = neg ? '0 : MAX_Q22;
                    state_next           = ST_OUT;
                end
                else
                begin
                    // Octaves as 5 integer bits and 32 fraction bits
                    div_req.start    = 1'b1;
                    div_req.rem_init = DIV_W'(num_reg >> QINT_W);
                    div_req.stream   = {num_reg[QINT_W-1:0], FRAC_W'(0)};
                    div_req.steps    = STEP_W'(QUOT_W);
                    div_req.divisor  = den_reg;
                    state_next       = ST_VDIV;
                end
            end
            ST_VDIV:
            begin
                if (div_done)
                begin
                    q_next    = div_quot[QUOT_W-1:FRAC_W];
                    fz_next   = (frac == '0);
                    exp_start = 1'b1;
                    if (neg && (frac != '0))
                        exp_frac = negf[FRAC_W-1:FRAC_W-EXP_STEPS];
                    else
                        exp_frac = frac[FRAC_W-1:FRAC_W-EXP_STEPS];
                    state_next = ST_EXP;
                end
            end
            ST_EXP:
            begin
                if (exp_done)
                begin
                    res_next.pitch_ratio = ratio_q22(exp_mant, q_reg, neg, fz_reg);
                    state_next           = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold the result until taken, then advance or drop back to idle
                if (!res_stall)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        num_next   = num_reg + NUM_W'(cf_reg);
                        state_next = ST_VOICE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            range_reg <= RANGE_RESET;
            d_reg     <= '0;
            vcnt_reg  <= '0;
            kfac_reg  <= '0;
            den_reg   <= '0;
            c_reg     <= '0;
            cf_reg    <= '0;
            num_reg   <= '0;
            idx_reg   <= '0;
            q_reg     <= '0;
            fz_reg    <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            range_reg <= range_next;
            d_reg     <= d_next;
            vcnt_reg  <= vcnt_next;
            kfac_reg  <= kfac_next;
            den_reg   <= den_next;
            c_reg     <= c_next;
            cf_reg    <= cf_next;
            num_reg   <= num_next;
            idx_reg   <= idx_next;
            q_reg     <= q_next;
            fz_reg    <= fz_next;
            res_reg   <= res_next;
        end
    end

endmodule

FILE: rtl/core/vdrs_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The partial remainder
// starts below the divisor; dividend bits enter MSB first from the stream.
module vdrs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  vdrs_pkg::div_req_t        req,
    output logic                      done,
    output logic [vdrs_pkg::QUOT_W-1:0] quot
);
    import vdrs_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  p_reg, p_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [QUOT_W-1:0] s_reg, s_next;
    logic [QUOT_W-1:0] q_reg, q_next;

    logic [DIV_W:0] p2;
    logic [DIV_W:0] pdiff;
    logic           ge;

    assign p2    = {p_reg, s_reg[QUOT_W-1]};
    assign ge    = p2 >= {1'b0, dvs_reg};
    assign pdiff = p2 - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        dvs_next  = dvs_reg;
        s_next    = s_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            p_next    = req.rem_init;
            dvs_next  = req.divisor;
            s_next    = req.stream;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                p_next   = ge ? pdiff[DIV_W-1:0] : p2[DIV_W-1:0];
                s_next   = {s_reg[QUOT_W-2:0], 1'b0};
                q_next   = {q_reg[QUOT_W-2:0], ge};
                cnt_next = cnt_reg - STEP_W'(1);
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            p_reg    <= '0;
            dvs_reg  <= '0;
            s_reg    <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            p_reg    <= p_next;
            dvs_reg  <= dvs_next;
            s_reg    <= s_next;
            q_reg    <= q_next;
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quot = q_reg;

endmodule

FILE: rtl/core/vdrs_exp2.sv
`timescale 1ns / 1ps

// 2^frac in Q1.30: one table step per fraction bit, multiplying for each set bit, highest weight first.
module vdrs_exp2 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [vdrs_pkg::EXP_STEPS-1:0] frac,
    output logic                           done,
    output logic [vdrs_pkg::MANT_W-1:0]    mant
);
    import vdrs_pkg::*;

    localparam int CNT_W = $clog2(EXP_STEPS + 1);
    localparam int TIX_W = $clog2(EXP_STEPS);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     st_reg, st_next;
    logic [EXP_STEPS-1:0] f_reg, f_next;
    logic [MANT_W-1:0]    m_reg, m_next;

    logic [2*MANT_W-1:0] prod;
    logic [2*MANT_W-1:0] prod_rnd;

    assign prod     = {{MANT_W{1'b0}}, m_reg}
                    * {{MANT_W{1'b0}}, ROOT_TAB[st_reg[TIX_W-1:0]]};
    assign prod_rnd = (prod + (2*MANT_W)'(64'h1 << 29)) >> 30;

    always_comb
    begin
        busy_next = busy_reg;
        st_next   = st_reg;
        f_next    = f_reg;
        m_next    = m_reg;
        if (start)
        begin
            busy_next = 1'b1;
            st_next   = '0;
            f_next    = frac;
            m_next    = MANT_W'(64'h1 << 30);
        end
        else if (busy_reg)
        begin
            if (st_reg != CNT_W'(EXP_STEPS))
            begin
                if (f_reg[EXP_STEPS-1])
                begin
                    m_next = prod_rnd[MANT_W-1:0];
                end
                f_next  = {f_reg[EXP_STEPS-2:0], 1'b0};
                st_next = st_reg + CNT_W'(1);
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            st_reg   <= '0;
            f_reg    <= '0;
            m_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            st_reg   <= st_next;
            f_reg    <= f_next;
            m_reg    <= m_next;
        end
    end

    assign done = busy_reg && (st_reg == CNT_W'(EXP_STEPS));
    assign mant = m_reg;

endmodule
